FILE: rtl/led_strip_animation_engine_core_assert.svh
// Assertion macros shared by the LED strip animation engine RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef LED_STRIP_ANIMATION_ENGINE_CORE_ASSERT_SVH
`define LED_STRIP_ANIMATION_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define LSAE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsae assertion failed");

// Next-cycle implication.
`define LSAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsae assertion failed");

`endif

FILE: rtl/lsae_pkg.sv
// Shared types, constants and arithmetic helpers for the LED strip animation engine.
// No dependencies.
`timescale 1ns / 1ps

package lsae_pkg;

  localparam int SEGMENTS    = 32;
  localparam int SEG_W       = 5;
  localparam int RAINBOW_LEN = 40;
  localparam int RB_MOD      = 2 * RAINBOW_LEN;

  // Configuration register indexes.
  localparam logic [2:0] REG_IDLE_MODE    = 3'd0;
  localparam logic [2:0] REG_TOUCHED_MODE = 3'd1;
  localparam logic [2:0] REG_BRIGHTNESS   = 3'd2;
  localparam logic [2:0] REG_SPEED        = 3'd3;
  localparam logic [2:0] REG_IDLE_COLOR   = 3'd4;
  localparam logic [2:0] REG_TOUCH_COLOR  = 3'd5;

  // Idle layer modes.
  localparam logic [2:0] IDLE_OFF     = 3'd0;
  localparam logic [2:0] IDLE_STATIC  = 3'd1;
  localparam logic [2:0] IDLE_PULSE   = 3'd2;
  localparam logic [2:0] IDLE_RB_CYC  = 3'd3;
  localparam logic [2:0] IDLE_RB_STAT = 3'd4;

  // Touched layer modes.
  localparam logic [2:0] TCH_OFF       = 3'd0;
  localparam logic [2:0] TCH_IDLE      = 3'd1;
  localparam logic [2:0] TCH_TOUCHED   = 3'd2;
  localparam logic [2:0] TCH_FADE      = 3'd3;
  localparam logic [2:0] TCH_IDLE_FADE = 3'd4;

  localparam logic [6:0] PULSE_MIN = 7'd40;
  localparam logic [6:0] PULSE_MAX = 7'd100;
  localparam logic [6:0] LEVEL_MAX = 7'd100;

  // One color: index 2 is red, 1 green, 0 blue.
  typedef logic [2:0][7:0] rgb_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic             load;
    logic             acc;
    logic             pprod;
    logic             mod_step;
    logic [2:0]       mod_k;
    logic             seg_a;
    logic             seg_b;
    logic             seg_c;
    logic             seg_d;
    logic [SEG_W-1:0] seg;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_free;
  } stat_t;

  localparam logic [23:0] RB_ROM0 [0:RAINBOW_LEN-1] = '{
    24'h5a3ac6, 24'h7636aa, 24'h91348e, 24'had3072, 24'hca2e56, 24'he62a3a, 24'hf22f2b,
    24'he64233, 24'hce5c46, 24'hb67459, 24'h9e8d6c, 24'h86a67e, 24'h6ebf90, 24'h57d8a3,
    24'h4ceaac, 24'h58f0a3, 24'h6df092, 24'h83f082, 24'h99f072, 24'haef061, 24'hc4f050,
    24'hdbf040, 24'hecea34, 24'hf2dc34, 24'hf4c938, 24'hf6b63c, 24'hf8a240, 24'hfa9045,
    24'hfc7d49, 24'hfe6a4d, 24'hf85c56, 24'he25668, 24'hc6527d, 24'haa5093, 24'h8e4ca9,
    24'h724abf, 24'h5646d5, 24'h3a44eb, 24'h2e40f3, 24'h3e3ce2
  };

  localparam logic [23:0] RB_ROM1 [0:RAINBOW_LEN-1] = '{
    24'h6838b7, 24'h83359c, 24'h9f3280, 24'hbb2f64, 24'hd82c48, 24'hf3292c, 24'hf2352a,
    24'hda4f3c, 24'hc36850, 24'haa8162, 24'h929975, 24'h7ab287, 24'h63cc9a, 24'h4be5ac,
    24'h4df0ab, 24'h62f09b, 24'h78f08a, 24'h8ef07a, 24'ha4f069, 24'hb9f059, 24'hd0f048,
    24'he6f037, 24'hf1e532, 24'hf3d236, 24'hf5c03a, 24'hf7ac3e, 24'hf99943, 24'hfb8647,
    24'hfd744b, 24'hff614f, 24'hf0575d, 24'hd45472, 24'hb75188, 24'h9c4e9e, 24'h804bb4,
    24'h6448ca, 24'h4845e0, 24'h2c42f6, 24'h2f3ef0, 24'h4c3bd4
  };

  // Rainbow lookup; entries past the table read as black.
  function automatic logic [23:0] rb_color(input logic half, input logic [5:0] off);
    logic [23:0] c;
    c = 24'd0;
    if (off < 6'(RAINBOW_LEN)) begin
      c = half ? RB_ROM1[off] : RB_ROM0[off];
    end
    return c;
  endfunction

  // Exact floor(x / 100) for x up to 255 * 100.
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = {13'd0, x} * 28'd5243;
    return p[26:19];
  endfunction

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

FILE: rtl/lsae_ctrl.sv
// Frame sequencer for the LED strip animation engine.
// Depends on lsae_pkg; drives commands into lsae_dp.
`timescale 1ns / 1ps

module lsae_ctrl import lsae_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_PPROD = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_SA    = 3'd4;
  localparam logic [2:0] ST_SB    = 3'd5;
  localparam logic [2:0] ST_SC    = 3'd6;
  localparam logic [2:0] ST_SD    = 3'd7;

  localparam logic [2:0] MOD_TOP = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       k_r, k_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    seg_nxt      = seg_r;
    cmd          = '0;
    cmd.mod_k    = k_r;
    cmd.seg      = seg_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_PPROD;
      end
      ST_PPROD: begin
        cmd.pprod = 1'b1;
        k_nxt     = MOD_TOP;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (k_r == 3'd0) begin
          seg_nxt   = '0;
          state_nxt = ST_SA;
        end else begin
          k_nxt = k_r - 3'd1;
        end
      end
      ST_SA: begin
        cmd.seg_a = 1'b1;
        state_nxt = ST_SB;
      end
      ST_SB: begin
        cmd.seg_b = 1'b1;
        state_nxt = ST_SC;
      end
      ST_SC: begin
        cmd.seg_c = 1'b1;
        state_nxt = ST_SD;
      end
      ST_SD: begin
        if (stat.out_free) begin
          cmd.seg_d = 1'b1;
          if (seg_r == SEG_W'(SEGMENTS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            seg_nxt   = seg_r + 1'b1;
            state_nxt = ST_SA;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      seg_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      seg_r   <= seg_nxt;
    end
  end

endmodule

FILE: rtl/lsae_dp.sv
// Datapath of the LED strip animation engine: registers, layers and color math.
// Depends on lsae_pkg; commanded by lsae_ctrl.
`timescale 1ns / 1ps

module lsae_dp import lsae_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data,
  input  logic [15:0]      in_elapsed_ms,
  input  logic [31:0]      in_touch_mask,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SEG_W-1:0] out_segment_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last_segment
);

  // Configuration registers.
  logic [2:0]  idle_mode_r, touched_mode_r;
  logic [7:0]  bright_r, speed_r;
  logic [23:0] idle_color_r, touched_color_r;

  // Frame and animation state.
  logic [23:0] steps_r;
  logic [31:0] mask_r;
  logic [11:0] pulse_acc_r, rainbow_acc_r;
  logic [10:0] fade_acc_r;
  logic [6:0]  blend_acc_r;
  logic [6:0]  pulse_level_r, blend_level_r, rainbow_pos_r;
  logic        pulse_rising_r;
  logic [13:0] fade_adv_r;
  logic [13:0] mod_val_r;
  logic [2:0][14:0] pprod_r;
  rgb_t        pulse_rgb_r;

  // Layer stores.
  logic [23:0] idle_layer_r    [SEGMENTS];
  logic [23:0] touched_layer_r [SEGMENTS];
  logic [6:0]  fade_levels_r   [SEGMENTS];

  // Per-segment pipeline registers.
  rgb_t             idle_new_r, told_r, tnew_r;
  logic [6:0]       fold_r;
  logic             tbit_r;
  logic [2:0][14:0] tprod_r, bprod_r;
  logic [2:0][15:0] brprod_r;

  // Output register.
  logic             out_valid_r;
  logic [SEG_W-1:0] out_idx_r;
  rgb_t             out_rgb_r;
  logic             out_last_r;

  assign out_valid         = out_valid_r;
  assign out_segment_index = out_idx_r;
  assign out_red           = out_rgb_r[2];
  assign out_green         = out_rgb_r[1];
  assign out_blue          = out_rgb_r[0];
  assign out_last_segment  = out_last_r;
  assign stat.out_free     = !out_valid_r || !out_stall;

  // Layer update enables.
  logic upd_idle, upd_touch, fade_mode;
  assign upd_idle  = (steps_r != 24'd0) && (idle_mode_r <= IDLE_RB_STAT);
  assign upd_touch = (touched_mode_r <= TCH_IDLE_FADE);
  assign fade_mode = (touched_mode_r == TCH_FADE) || (touched_mode_r == TCH_IDLE_FADE);

  // Accumulator sums for this frame.
  logic [24:0] p_tot, r_tot, f_tot, b_tot;
  logic [12:0] adv_p, adv_r;
  logic [17:0] adv_b;
  logic [13:0] pulse_sum;
  logic [18:0] blend_sum;
  logic [6:0]  pulse_nxt, blend_nxt;
  logic        rising_nxt;

  assign p_tot = {13'd0, pulse_acc_r} + {1'b0, steps_r};
  assign r_tot = {13'd0, rainbow_acc_r} + {1'b0, steps_r};
  assign f_tot = {14'd0, fade_acc_r} + {1'b0, steps_r};
  assign b_tot = {18'd0, blend_acc_r} + {1'b0, steps_r};
  assign adv_p = p_tot[24:12];
  assign adv_r = r_tot[24:12];
  assign adv_b = b_tot[24:7];
  assign pulse_sum = {7'd0, pulse_level_r} + {1'b0, adv_p};
  assign blend_sum = {12'd0, blend_level_r} + {1'b0, adv_b};

  // Pulse bounce between its limits.
  always_comb begin
    rising_nxt = pulse_rising_r;
    if (!pulse_rising_r && ({6'd0, pulse_level_r - PULSE_MIN} <= adv_p)) begin
      pulse_nxt  = PULSE_MIN;
      rising_nxt = 1'b1;
    end else if (pulse_rising_r && (pulse_sum >= {7'd0, PULSE_MAX})) begin
      pulse_nxt  = PULSE_MAX;
      rising_nxt = 1'b0;
    end else if (pulse_rising_r) begin
      pulse_nxt = pulse_level_r + adv_p[6:0];
    end else begin
      pulse_nxt = pulse_level_r - adv_p[6:0];
    end
  end

  // Blend level falls while touched, rises otherwise.
  always_comb begin
    if (mask_r != 32'd0) begin
      blend_nxt = (adv_b > {11'd0, blend_level_r}) ? 7'd0 : blend_level_r - adv_b[6:0];
    end else begin
      blend_nxt = (blend_sum > {12'd0, LEVEL_MAX}) ? LEVEL_MAX : blend_level_r + adv_b[6:0];
    end
  end

  // Restoring reduction of the rainbow position.
  logic [13:0] mod_thr, mod_res;
  assign mod_thr = 14'(RB_MOD) << cmd.mod_k;
  assign mod_res = (mod_val_r >= mod_thr) ? mod_val_r - mod_thr : mod_val_r;

  // Segment stage A: new idle color and fade products.
  logic [6:0]  rb_off;
  logic [23:0] rb_c;
  rgb_t        idle_old, idle_calc, tch_old;
  logic [6:0]  fade_old;
  assign idle_old = idle_layer_r[cmd.seg];
  assign tch_old  = touched_layer_r[cmd.seg];
  assign fade_old = fade_levels_r[cmd.seg];

  always_comb begin
    rb_off = {1'b0, rainbow_pos_r[6:1]} + {2'd0, cmd.seg};
    if (rb_off >= 7'(RAINBOW_LEN)) begin
      rb_off = rb_off - 7'(RAINBOW_LEN);
    end
    rb_c      = rb_color(rainbow_pos_r[0], rb_off[5:0]);
    idle_calc = idle_old;
    if (upd_idle) begin
      case (idle_mode_r)
        IDLE_OFF:     idle_calc = '0;
        IDLE_STATIC:  idle_calc = idle_color_r;
        IDLE_PULSE:   idle_calc = pulse_rgb_r;
        IDLE_RB_CYC:  idle_calc = rb_c;
        IDLE_RB_STAT: idle_calc = rb_c;
        default:      idle_calc = idle_old;
      endcase
    end
  end

  // Segment stage B: new touched color and fade level.
  rgb_t       tch_calc;
  logic [6:0] fade_calc;
  always_comb begin
    fade_calc = fold_r;
    case (touched_mode_r)
      TCH_OFF:     tch_calc = '0;
      TCH_IDLE:    tch_calc = idle_new_r;
      TCH_TOUCHED: tch_calc = tbit_r ? rgb_t'(touched_color_r) : '0;
      TCH_FADE, TCH_IDLE_FADE: begin
        if (tbit_r) begin
          tch_calc  = (touched_mode_r == TCH_FADE) ? rgb_t'(touched_color_r) : idle_new_r;
          fade_calc = LEVEL_MAX;
        end else begin
          for (int c = 0; c < 3; c++) begin
            tch_calc[c] = div100(tprod_r[c]);
          end
          fade_calc = (fade_adv_r > {7'd0, fold_r}) ? 7'd0 : fold_r - fade_adv_r[6:0];
        end
      end
      default: tch_calc = told_r;
    endcase
  end

  // Segment stage C: blend and per-channel maximum.
  rgb_t blended;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blended[c] = (div100(bprod_r[c]) > tnew_r[c]) ? div100(bprod_r[c]) : tnew_r[c];
    end
  end

  logic [SEG_W-1:0] mask_idx;
  assign mask_idx = SEG_W'(SEGMENTS - 1) - cmd.seg;

  // Configuration and frame-level state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_mode_r     <= IDLE_OFF;
      touched_mode_r  <= TCH_OFF;
      bright_r        <= 8'd255;
      speed_r         <= 8'd1;
      idle_color_r    <= 24'd0;
      touched_color_r <= 24'hFFFFFF;
      pulse_acc_r     <= '0;
      rainbow_acc_r   <= '0;
      fade_acc_r      <= '0;
      blend_acc_r     <= '0;
      pulse_level_r   <= PULSE_MAX;
      pulse_rising_r  <= 1'b0;
      rainbow_pos_r   <= '0;
      blend_level_r   <= LEVEL_MAX;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_IDLE_MODE:    idle_mode_r     <= cfg_data[2:0];
          REG_TOUCHED_MODE: touched_mode_r  <= cfg_data[2:0];
          REG_BRIGHTNESS:   bright_r        <= cfg_data[7:0];
          REG_SPEED:        speed_r         <= cfg_data[7:0];
          REG_IDLE_COLOR:   idle_color_r    <= cfg_data;
          REG_TOUCH_COLOR:  touched_color_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.acc) begin
        if (upd_idle && (idle_mode_r == IDLE_PULSE)) begin
          pulse_acc_r    <= p_tot[11:0];
          pulse_level_r  <= pulse_nxt;
          pulse_rising_r <= rising_nxt;
        end
        if (upd_idle && (idle_mode_r == IDLE_RB_CYC)) begin
          rainbow_acc_r <= r_tot[11:0];
        end
        if (fade_mode) begin
          fade_acc_r <= f_tot[10:0];
        end
        blend_acc_r   <= b_tot[6:0];
        blend_level_r <= blend_nxt;
      end
      if (cmd.mod_step && (cmd.mod_k == 3'd0)) begin
        rainbow_pos_r <= mod_res[6:0];
      end
    end
  end

  // Frame payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steps_r <= in_elapsed_ms * speed_r;
      mask_r  <= in_touch_mask;
    end
    if (cmd.acc) begin
      fade_adv_r <= f_tot[24:11];
      if (upd_idle && (idle_mode_r == IDLE_RB_CYC)) begin
        mod_val_r <= {7'd0, rainbow_pos_r} + {1'b0, adv_r};
      end else begin
        mod_val_r <= {7'd0, rainbow_pos_r};
      end
    end
    if (cmd.pprod) begin
      for (int c = 0; c < 3; c++) begin
        pprod_r[c] <= idle_color_r[c*8 +: 8] * pulse_level_r;
      end
    end
    if (cmd.mod_step) begin
      mod_val_r <= mod_res;
      for (int c = 0; c < 3; c++) begin
        pulse_rgb_r[c] <= div100(pprod_r[c]);
      end
    end
    if (cmd.seg_a) begin
      idle_new_r <= idle_calc;
      told_r     <= tch_old;
      fold_r     <= fade_old;
      tbit_r     <= mask_r[mask_idx];
      for (int c = 0; c < 3; c++) begin
        tprod_r[c] <= tch_old[c] * fade_old;
      end
    end
    if (cmd.seg_b) begin
      tnew_r <= tch_calc;
      for (int c = 0; c < 3; c++) begin
        bprod_r[c] <= idle_new_r[c] * blend_level_r;
      end
    end
    if (cmd.seg_c) begin
      for (int c = 0; c < 3; c++) begin
        brprod_r[c] <= blended[c] * bright_r;
      end
    end
    if (cmd.seg_d) begin
      out_idx_r  <= cmd.seg;
      out_last_r <= (cmd.seg == SEG_W'(SEGMENTS - 1));
      for (int c = 0; c < 3; c++) begin
        out_rgb_r[c] <= div255(brprod_r[c]);
      end
    end
  end

  // Layer stores, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEGMENTS; i++) begin
        idle_layer_r[i]    <= '0;
        touched_layer_r[i] <= '0;
        fade_levels_r[i]   <= '0;
      end
    end else if (cmd.seg_b) begin
      idle_layer_r[cmd.seg] <= idle_new_r;
      if (upd_touch) begin
        touched_layer_r[cmd.seg] <= tch_calc;
      end
      if (fade_mode) begin
        fade_levels_r[cmd.seg] <= fade_calc;
      end
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.seg_d) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/led_strip_animation_engine_core.sv
// Top level of the LED strip animation engine: sequencer plus datapath.
// Depends on lsae_pkg, lsae_ctrl, lsae_dp and the assertion macro header.
`timescale 1ns / 1ps

// Each input word is one frame tick; it produces 32 output words, one per segment in
// order, the last flagged by out_last_segment. The step count is formed at the edge
// that accepts the word. The sequencer then advances the accumulators, forms the pulse
// color product and runs the bit-serial reduction of the rainbow position, then passes
// each segment through the shared color pipeline (layer update, fade dim, blend and
// maximum, brightness). No new frame is taken until the final segment word is loaded.
// A new frame is taken while the final segment word still waits on the output.
// Configuration writes are always taken and must only be issued between frames.
module led_strip_animation_engine_core import lsae_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [15:0]      in_elapsed_ms,
  input  logic [31:0]      in_touch_mask,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SEG_W-1:0] out_segment_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last_segment,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_data
);

`include "led_strip_animation_engine_core_assert.svh"

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  lsae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsae_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_elapsed_ms     (in_elapsed_ms),
    .in_touch_mask     (in_touch_mask),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_segment_index (out_segment_index),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_segment  (out_last_segment)
  );

  // The sequencer is busy right after taking a frame.
  `LSAE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // The last flag marks only the final segment.
  `LSAE_ASSERT_NOW(a_last_index, out_valid && out_last_segment,
                   out_segment_index == SEG_W'(SEGMENTS - 1))
  // A new output word is loaded only when the register is free.
  `LSAE_ASSERT_NOW(a_no_overwrite, cmd.seg_d, !out_valid || !out_stall)

endmodule
